FILE: rtl/bir90_pkg.sv
package bir90_pkg;

	// Fixed field widths
	localparam int ROW_W  = 64;
	localparam int DIM_W  = 7;
	localparam int COL_W  = 6;
	localparam int CIDX_W = 8;

	localparam int MAX_DIM_DEF = 64;

	// Register indexes
	localparam logic [CIDX_W-1:0] REG_IMG_WIDTH   = 8'd0;
	localparam logic [CIDX_W-1:0] REG_IMG_HEIGHT  = 8'd1;
	localparam logic [CIDX_W-1:0] REG_ROT_CW      = 8'd2;
	localparam logic [CIDX_W-1:0] REG_INVERT      = 8'd3;

	localparam logic [DIM_W-1:0] IMG_WIDTH_RST  = 7'd64;
	localparam logic [DIM_W-1:0] IMG_HEIGHT_RST = 7'd64;

	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} state_t;

	// Control from the sequencer to the row store
	typedef struct packed {
		logic             we;
		logic [COL_W-1:0] col;
	} store_ctl_t;

	// Clamp a dimension register into 1..max_dim
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] max_dim);
		logic [DIM_W-1:0] res;
		begin
			res = v;
			if (v == '0) begin
				res = DIM_W'(1);
			end else if (v > max_dim) begin
				res = max_dim;
			end
			return res;
		end
	endfunction

endpackage

FILE: rtl/bir90_store.sv
module bir90_store import bir90_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  store_ctl_t                 ctl,
	input  logic [$clog2(MAX_DIM)-1:0] waddr,
	input  logic [ROW_W-1:0]           wdata,
	output logic [MAX_DIM-1:0]         col_bits_s1,
	output logic                       col_valid_s1,
	input  logic                       col_req
);

	logic [ROW_W-1:0]   store_q [MAX_DIM];
	logic [MAX_DIM-1:0] col_bits;

	// Write one row per accepted transaction
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			store_q[waddr] <= wdata;
		end
	end

	// Pick the selected column out of every stored row
	always_comb begin
		for (int i = 0; i < MAX_DIM; i++) begin
			col_bits[i] = store_q[i][ctl.col];
		end
	end

	// Register the gathered column
	always_ff @(posedge clk) begin
		col_bits_s1 <= col_bits;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_valid_s1 <= 1'b0;
		end else begin
			col_valid_s1 <= col_req;
		end
	end

endmodule

FILE: rtl/bit_image_rotate_90_top.sv
// Rotates a one-bit-per-pixel image by 90 degrees.
// Input: pulse start with a row on row_pixels (pixel j at bit j) while busy is
// low; the row is taken at that clock edge, rows top to bottom, one per cycle.
// The row that completes the image (img_height rows) starts the output phase:
// busy rises and img_width rotated rows follow, one per cycle, each on
// out_row_pixels for exactly one cycle with out_valid high; last_row marks the
// final one. After the completing row, each result passes the state register,
// the column register in the row store and the output register; busy stays
// high while the columns are issued. One column is gathered from the register
// row store each cycle by a single column select unit, then oriented, masked
// and inverted in a second stage.
// Registers are written over cfg_valid/cfg_ready (always ready) by index:
// 0 img_width, 1 img_height, 2 rotate_clockwise, 3 invert_pixels; other
// indexes are ignored. Write them only while the block is idle.
// Reset clears the row count and puts the registers at 64, 64, 0, 0.
// The receiver cannot stall; out_valid is a strobe.
module bit_image_rotate_90_top import bir90_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [ROW_W-1:0]  row_pixels,
	output logic              out_valid,
	output logic [ROW_W-1:0]  out_row_pixels,
	output logic              last_row,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]  cfg_data
);

	localparam int ADDR_W = $clog2(MAX_DIM);
	localparam int CNT_W  = $clog2(MAX_DIM + 1);
	localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

	logic [DIM_W-1:0] img_width_q;
	logic [DIM_W-1:0] img_height_q;
	logic             rot_cw_q;
	logic             invert_q;

	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] rows_loaded_q;
	logic [DIM_W-1:0] r_q;
	logic [DIM_W-1:0] cnt_next;
	logic             accept;
	logic             complete;
	logic             issue;
	logic             issue_last;
	logic [DIM_W-1:0] col_full;

	store_ctl_t         ctl;
	logic [MAX_DIM-1:0] col_bits_s1;
	logic               col_valid_s1;
	logic               last_s1;

	logic [MAX_DIM-1:0] rev;
	logic [MAX_DIM-1:0] shifted;
	logic [MAX_DIM-1:0] oriented;
	logic [MAX_DIM-1:0] mask;
	logic [MAX_DIM-1:0] pix;
	logic [ROW_W-1:0]   pix_wide;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_width_q  <= IMG_WIDTH_RST;
			img_height_q <= IMG_HEIGHT_RST;
			rot_cw_q     <= 1'b0;
			invert_q     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IMG_WIDTH:  img_width_q  <= cfg_data;
				REG_IMG_HEIGHT: img_height_q <= cfg_data;
				REG_ROT_CW:     rot_cw_q     <= cfg_data[0];
				REG_INVERT:     invert_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign w_eff = eff_dim(img_width_q, MAX_DIM_V);
	assign h_eff = eff_dim(img_height_q, MAX_DIM_V);

	// Sequencer
	assign busy       = (state_q == ST_EMIT);
	assign accept     = start && !busy;
	assign cnt_next   = DIM_W'(rows_loaded_q) + DIM_W'(1);
	assign complete   = accept && (cnt_next >= h_eff);
	assign issue      = (state_q == ST_EMIT);
	assign issue_last = (r_q == w_eff - DIM_W'(1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (complete) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (issue_last) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_LOAD;
			rows_loaded_q <= '0;
			r_q           <= '0;
		end else begin
			state_q <= state_d;
			if (complete) begin
				rows_loaded_q <= '0;
			end else if (accept) begin
				rows_loaded_q <= CNT_W'(cnt_next);
			end
			if (issue) begin
				r_q <= r_q + DIM_W'(1);
			end else begin
				r_q <= '0;
			end
		end
	end

	// Column of the source image for this output row
	always_comb begin
		col_full = rot_cw_q ? r_q : (w_eff - DIM_W'(1) - r_q);
		ctl.we   = accept;
		ctl.col  = col_full[COL_W-1:0];
	end

	bir90_store #(
		.MAX_DIM(MAX_DIM)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.waddr       (rows_loaded_q[ADDR_W-1:0]),
		.wdata       (row_pixels),
		.col_bits_s1 (col_bits_s1),
		.col_valid_s1(col_valid_s1),
		.col_req     (issue)
	);

	always_ff @(posedge clk) begin
		last_s1 <= issue_last;
	end

	// Orient, mask and invert the gathered column
	always_comb begin
		for (int k = 0; k < MAX_DIM; k++) begin
			rev[k]  = col_bits_s1[MAX_DIM-1-k];
			mask[k] = (DIM_W'(k) < h_eff);
		end
		shifted  = rev >> (MAX_DIM_V - h_eff);
		oriented = rot_cw_q ? shifted : col_bits_s1;
		pix      = (oriented ^ (invert_q ? mask : '0)) & mask;
		pix_wide = '0;
		pix_wide[MAX_DIM-1:0] = pix;
	end

	// Drive the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= col_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		out_row_pixels <= pix_wide;
		last_row       <= last_s1 && col_valid_s1;
	end

	// Checks
	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (r_q < w_eff))
		else $error("output row counter beyond width");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		DIM_W'(rows_loaded_q) < MAX_DIM_V)
		else $error("row count reached store depth");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_row) |=> !out_valid)
		else $error("result right after last row");

	a_last_has_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && issue_last) |=> ##1 (out_valid && last_row))
		else $error("last row not delivered");

endmodule
